// File: rtl/core/lsfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsfs_pkg: shared types and constants of the led strip frame streamer
// Frame buffer sizing, entry layout, command codes and the write request
// into the buffer.
// ----------------------------------------------------------------------------
package lsfs_pkg;

  // number of leds on the strip (2 to 63)
  localparam int unsigned LedCount = 32;
  // physical address width of the frame buffer
  localparam int unsigned AddrW    = $clog2(LedCount);
  // width of a logical led position, same as the index field
  localparam int unsigned PosW     = 6;

  // word framing
  localparam logic [31:0] StartWord = 32'h0000_0000;
  localparam logic [31:0] EndWord   = 32'hFFFF_FFFF;
  localparam logic [2:0]  LedHeader = 3'b111;

  // command codes; the two spare codes are ignored
  typedef enum logic [2:0] {
    CmdSetOne  = 3'd0,
    CmdSetSend = 3'd1,
    CmdSetAll  = 3'd2,
    CmdSend    = 3'd3,
    CmdShift   = 3'd4,
    CmdRotate  = 3'd5,
    CmdSpare6  = 3'd6,
    CmdSpare7  = 3'd7
  } cmd_e;

  typedef logic [AddrW-1:0] addr_t;

  // one led setting, packed as level, blue, green, red
  typedef struct packed {
    logic [4:0] level;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } entry_t;

  // write request into the frame buffer
  typedef struct packed {
    logic   en;
    addr_t  addr;
    entry_t data;
  } wr_req_t;

endpackage
`default_nettype wire

// File: rtl/core/lsfs_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsfs_store: frame buffer of led settings
// One write port, one registered read port; per-entry valid bits make
// entries that were never written since reset read as zero.
// ----------------------------------------------------------------------------
module lsfs_store import lsfs_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire wr_req_t wr_i,
  input  wire addr_t   rd_addr_i,
  output entry_t       rd_data_o
);

  entry_t                mem_q [LedCount];
  logic   [LedCount-1:0] valid_q;
  entry_t                rd_data_q;
  logic                  rd_valid_q;

  // storage array and read data
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  // valid bits, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      rd_valid_q <= valid_q[rd_addr_i];
    end
  end

  // unwritten entries read as zero
  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule
`default_nettype wire

// File: rtl/core/led_strip_frame_streamer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// led_strip_frame_streamer: frame buffer and word streamer for a two-wire
// rgb led strip
// Commands set one or all leds, shift or rotate the buffer, and send the
// whole frame as a start word, one word per led and an end word.
// ----------------------------------------------------------------------------
// channel   ports                                    handshake
// command   cmd_i index_i level_i red_i green_i      start high, busy low
//           blue_i direction_i positions_i
// word      frame_word_o last_o                      word_valid_o, one cycle
//
// busy per command: set one writes in StWrite, set one and send adds a send,
// set all sends, shift or rotate run StPrep and StAdjust first; a send gives
// LedCount+2 words at one per cycle, set by the single read port of the buffer.
// Shift and rotate move a base pointer through one shared modulo adder,
// which also walks the read address; zero fill is written during the send.
// Reset clears the buffer at once through valid bits; no clearing pass.
// Words cannot be stalled; each is registered in word_q after its buffer read.
// ----------------------------------------------------------------------------
module led_strip_frame_streamer import lsfs_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  cmd_i,
  input  wire logic [5:0]  index_i,
  input  wire logic [4:0]  level_i,
  input  wire logic [7:0]  red_i,
  input  wire logic [7:0]  green_i,
  input  wire logic [7:0]  blue_i,
  input  wire logic        direction_i,
  input  wire logic [7:0]  positions_i,
  output logic [31:0]      frame_word_o,
  output logic             last_o,
  output logic             word_valid_o
);

  typedef enum logic [2:0] {
    StIdle,
    StWrite,
    StPrep,
    StAdjust,
    StHead,
    StBody,
    StTail
  } state_e;

  localparam logic [PosW-1:0] CountPos = PosW'(LedCount);
  localparam logic [PosW-1:0] LastPos  = PosW'(LedCount - 1);

  // remainder of an amount by the led count, restoring steps
  function automatic logic [PosW-1:0] reduce_amount(input logic [7:0] n);
    logic [15:0] r;
    r = {8'b0, n};
    for (int k = 7; k >= 0; k--) begin
      if (r >= (16'(LedCount) << k)) begin
        r = r - (16'(LedCount) << k);
      end
    end
    return r[PosW-1:0];
  endfunction

  state_e          state_q;
  cmd_e            cmd_q;
  logic [PosW-1:0] idx_q;
  entry_t          entry_q;
  logic            dir_q;
  logic [7:0]      n_q;
  logic [PosW-1:0] amt_q;
  logic [PosW-1:0] thr_q;
  logic            long_q;
  addr_t           base_q;
  addr_t           rd_ptr_q;
  logic [PosW-1:0] pos_q;
  logic [31:0]     word_q;
  logic            last_q;
  logic            strobe_q;

  logic [PosW-1:0] unit_a;
  logic [PosW-1:0] unit_b;
  logic [PosW:0]   unit_sum;
  logic [PosW:0]   unit_wrap;
  addr_t           unit_res;
  logic [PosW-1:0] amt_comp;
  logic            vacated;
  entry_t          rd_data;
  entry_t          body_entry;
  wr_req_t         wr_req;

  assign amt_comp = CountPos - amt_q;

  // shared modulo adder: operand select per step
  always_comb begin
    unit_a = '0;
    unit_b = '0;
    case (state_q)
      StWrite: begin
        unit_a = idx_q;
        unit_b = PosW'(base_q);
      end
      StAdjust: begin
        unit_a = PosW'(base_q);
        unit_b = dir_q ? amt_comp : amt_q;
      end
      StHead: begin
        unit_a = PosW'(base_q);
      end
      StBody: begin
        unit_a = PosW'(rd_ptr_q);
        unit_b = PosW'(1);
      end
      default: begin
        unit_a = '0;
        unit_b = '0;
      end
    endcase
  end

  assign unit_sum  = {1'b0, unit_a} + {1'b0, unit_b};
  assign unit_wrap = (unit_sum >= {1'b0, CountPos}) ? unit_sum - {1'b0, CountPos} : unit_sum;
  assign unit_res  = unit_wrap[AddrW-1:0];

  // positions emptied by a shift
  always_comb begin
    vacated = 1'b0;
    if (cmd_q == CmdShift) begin
      vacated = long_q || (dir_q ? (pos_q < thr_q) : (pos_q >= thr_q));
    end
  end

  // entry sent for the current position
  always_comb begin
    body_entry = rd_data;
    if (cmd_q == CmdSetAll) begin
      body_entry = entry_q;
    end else if (vacated) begin
      body_entry = '0;
    end
  end

  // buffer writes: set one, set all and zero fill
  always_comb begin
    wr_req = '0;
    case (state_q)
      StWrite: begin
        wr_req.en   = (idx_q < CountPos);
        wr_req.addr = unit_res;
        wr_req.data = entry_q;
      end
      StBody: begin
        wr_req.en   = (cmd_q == CmdSetAll) || vacated;
        wr_req.addr = rd_ptr_q;
        wr_req.data = body_entry;
      end
      default: begin
        wr_req = '0;
      end
    endcase
  end

  lsfs_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr_req),
    .rd_addr_i (unit_res),
    .rd_data_o (rd_data)
  );

  // command payload capture
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      idx_q   <= index_i;
      entry_q <= '{level: level_i, blue: blue_i, green: green_i, red: red_i};
      dir_q   <= direction_i;
      n_q     <= positions_i;
    end
    if (state_q == StPrep) begin
      amt_q <= reduce_amount(n_q);
    end
    if (state_q == StAdjust) begin
      thr_q <= dir_q ? amt_q : amt_comp;
    end
    case (state_q)
      StBody:  word_q <= {LedHeader, body_entry};
      StTail:  word_q <= EndWord;
      default: word_q <= StartWord;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cmd_q    <= CmdSend;
      long_q   <= 1'b0;
      base_q   <= '0;
      rd_ptr_q <= '0;
      pos_q    <= '0;
      last_q   <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
      case (state_q)
        StIdle: begin
          if (start) begin
            cmd_q <= cmd_e'(cmd_i);
            case (cmd_e'(cmd_i))
              CmdSetOne, CmdSetSend: state_q <= StWrite;
              CmdSetAll, CmdSend:    state_q <= StHead;
              CmdShift, CmdRotate:   state_q <= StPrep;
              default:               state_q <= StIdle;
            endcase
          end
        end
        StWrite: begin
          state_q <= (cmd_q == CmdSetSend) ? StHead : StIdle;
        end
        StPrep: begin
          long_q  <= (cmd_q == CmdShift) && (n_q >= 8'(LedCount));
          state_q <= StAdjust;
        end
        StAdjust: begin
          base_q  <= unit_res;
          state_q <= StHead;
        end
        StHead: begin
          strobe_q <= 1'b1;
          rd_ptr_q <= unit_res;
          pos_q    <= '0;
          state_q  <= StBody;
        end
        StBody: begin
          strobe_q <= 1'b1;
          if (pos_q == LastPos) begin
            state_q <= StTail;
          end else begin
            pos_q    <= pos_q + PosW'(1);
            rd_ptr_q <= unit_res;
          end
        end
        StTail: begin
          strobe_q <= 1'b1;
          last_q   <= 1'b1;
          pos_q    <= '0;
          long_q   <= 1'b0;
          state_q  <= StIdle;
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign busy         = (state_q != StIdle);
  assign frame_word_o = word_q;
  assign last_o       = last_q;
  assign word_valid_o = strobe_q;

endmodule
`default_nettype wire
